>>> sv/sops_pkg.sv
`timescale 1ns / 1ps

package sops_pkg;

  // Sizes of the stores and fields.
  localparam int Nodes     = 16;
  localparam int MaxPath   = 8;
  localparam int NodeW     = 4;
  localparam int DistW     = 20;
  localparam int SumW      = 24;
  localparam int TotW      = 23;
  localparam int PosW      = 3;
  localparam int CmdW      = 2;
  localparam int LvlW      = $clog2(MaxPath);
  localparam int CntW      = $clog2(MaxPath + 1);
  localparam int DistAw    = 2 * NodeW;
  localparam int DistDepth = Nodes * Nodes;

  // Best length before any path is found: all ones means infinite.
  localparam logic [SumW-1:0] LenInf = '1;

  // Command codes of an input beat.
  localparam logic [CmdW-1:0] CmdWrite  = 2'd0;
  localparam logic [CmdW-1:0] CmdAppend = 2'd1;
  localparam logic [CmdW-1:0] CmdStart  = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    SIdle,
    SEnter,
    SFetch,
    SStep,
    SReturn,
    SOut,
    SNoPath
  } sops_state_e;

endpackage

>>> sv/shortest_open_path_search_top.sv
`timescale 1ns / 1ps
// Load beats (write, append) are taken one per cycle while idle and give no result.
// A start beat with fewer than two nodes gives its no-path beat on the next cycle.
// Otherwise a depth-first search runs: each node entered passes SEnter, SStep
// (only SEnter if pruned), each return SReturn, each further branch SFetch, SStep.
// The tree has up to (n-1)! leaves; then n result beats follow, one per cycle when taken.
// Reset clears the sequencer, counters, sums and best length; the stores hold no reset.

module shortest_open_path_search_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [sops_pkg::CmdW-1:0]        command_i,
  input  logic [sops_pkg::NodeW-1:0]       from_node_i,
  input  logic [sops_pkg::NodeW-1:0]       to_node_i,
  input  logic [sops_pkg::DistW-1:0]       distance_i,
  input  logic [sops_pkg::NodeW-1:0]       node_id_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sops_pkg::NodeW-1:0]       order_node_o,
  output logic [sops_pkg::PosW-1:0]        position_o,
  output logic [sops_pkg::TotW-1:0]        total_length_o,
  output logic                             no_path_o,
  output logic                             last_o
);

  sops_pkg::sops_state_e state_q, state_d;

  logic [sops_pkg::CntW-1:0]  count_q, count_d;
  logic [sops_pkg::CntW-1:0]  n_q, n_d;
  logic [sops_pkg::LvlW-1:0]  lvl_q, lvl_d;
  logic [sops_pkg::LvlW-1:0]  k_q, k_d;
  logic                       fresh_q, fresh_d;
  logic [sops_pkg::SumW-1:0]  best_len_q, best_len_d;
  logic [sops_pkg::LvlW-1:0]  cnt_q [sops_pkg::MaxPath];
  logic [sops_pkg::LvlW-1:0]  cnt_d [sops_pkg::MaxPath];
  logic [sops_pkg::SumW-1:0]  psum_q [sops_pkg::MaxPath];
  logic [sops_pkg::SumW-1:0]  psum_d [sops_pkg::MaxPath];
  logic [sops_pkg::NodeW-1:0] path_q [sops_pkg::MaxPath];
  logic [sops_pkg::NodeW-1:0] path_d [sops_pkg::MaxPath];
  logic [sops_pkg::NodeW-1:0] best_ord_q [sops_pkg::MaxPath];
  logic [sops_pkg::NodeW-1:0] best_ord_d [sops_pkg::MaxPath];

  logic                        in_fire;
  logic                        out_fire;
  logic                        out_last;
  logic [sops_pkg::LvlW-1:0]   lvl_nxt;
  logic [sops_pkg::LvlW-1:0]   parent;
  logic [sops_pkg::SumW-1:0]   sum;
  logic [sops_pkg::SumW-1:0]   add_sum;
  logic [sops_pkg::CntW-1:0]   size;
  logic                        prune;
  logic                        leaf;
  logic [sops_pkg::NodeW-1:0]  head;
  logic [sops_pkg::DistW-1:0]  rdata;
  logic                        ram_we;
  logic [sops_pkg::DistAw-1:0] ram_raddr;

  // Distance store, addressed by row and column node.
  sops_ram #(
    .Width (sops_pkg::DistW),
    .Depth (sops_pkg::DistDepth)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({from_node_i, to_node_i}),
    .wdata_i (distance_i),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // Shared datapath terms: one adder and the compares around it.
  assign in_fire   = in_valid_i && in_ready_o;
  assign out_fire  = out_valid_o && out_ready_i;
  assign lvl_nxt   = lvl_q + 1'b1;
  assign parent    = lvl_q - 1'b1;
  assign sum       = psum_q[lvl_q];
  assign add_sum   = sum + sops_pkg::SumW'(rdata);
  assign size      = n_q - sops_pkg::CntW'(lvl_q);
  assign prune     = best_len_q < sum;
  assign leaf      = size == sops_pkg::CntW'(2);
  assign head      = path_q[lvl_q];
  assign out_last  = sops_pkg::CntW'(k_q) == n_q - 1'b1;
  assign ram_we    = in_fire && (command_i == sops_pkg::CmdWrite);
  assign ram_raddr = {path_q[lvl_q], path_q[lvl_nxt]};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sops_pkg::SIdle: begin
        if (in_valid_i && command_i == sops_pkg::CmdStart) begin
          if (count_q < sops_pkg::CntW'(2)) begin
            state_d = sops_pkg::SNoPath;
          end else begin
            state_d = sops_pkg::SEnter;
          end
        end
      end
      sops_pkg::SEnter: begin
        state_d = prune ? sops_pkg::SReturn : sops_pkg::SStep;
      end
      sops_pkg::SFetch: begin
        state_d = sops_pkg::SStep;
      end
      sops_pkg::SStep: begin
        state_d = leaf ? sops_pkg::SReturn : sops_pkg::SEnter;
      end
      sops_pkg::SReturn: begin
        if (lvl_q == '0) begin
          state_d = sops_pkg::SOut;
        end else if (cnt_q[parent] == sops_pkg::LvlW'(1)) begin
          state_d = sops_pkg::SReturn;
        end else begin
          state_d = sops_pkg::SFetch;
        end
      end
      sops_pkg::SOut: begin
        if (out_ready_i && out_last) begin
          state_d = sops_pkg::SIdle;
        end
      end
      sops_pkg::SNoPath: begin
        if (out_ready_i) begin
          state_d = sops_pkg::SIdle;
        end
      end
      default: begin
        state_d = sops_pkg::SIdle;
      end
    endcase
  end

  // Handshake and result fields.
  always_comb begin
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    order_node_o   = '0;
    position_o     = '0;
    total_length_o = '0;
    no_path_o      = 1'b0;
    last_o         = 1'b0;
    case (state_q)
      sops_pkg::SIdle: begin
        in_ready_o = 1'b1;
      end
      sops_pkg::SOut: begin
        out_valid_o    = 1'b1;
        order_node_o   = best_ord_q[k_q];
        position_o     = sops_pkg::PosW'(k_q);
        total_length_o = best_len_q[sops_pkg::TotW-1:0];
        last_o         = out_last;
      end
      sops_pkg::SNoPath: begin
        out_valid_o = 1'b1;
        no_path_o   = 1'b1;
        last_o      = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Datapath updates for each sequencer step.
  always_comb begin
    count_d    = count_q;
    n_d        = n_q;
    lvl_d      = lvl_q;
    k_d        = k_q;
    fresh_d    = fresh_q;
    best_len_d = best_len_q;
    cnt_d      = cnt_q;
    psum_d     = psum_q;
    path_d     = path_q;
    best_ord_d = best_ord_q;
    case (state_q)
      sops_pkg::SIdle: begin
        if (in_fire && command_i == sops_pkg::CmdAppend &&
            count_q < sops_pkg::CntW'(sops_pkg::MaxPath)) begin
          path_d[count_q[sops_pkg::LvlW-1:0]] = node_id_i;
          count_d = count_q + 1'b1;
        end
        if (in_fire && command_i == sops_pkg::CmdStart) begin
          n_d        = count_q;
          count_d    = '0;
          best_len_d = sops_pkg::LenInf;
          lvl_d      = '0;
          k_d        = '0;
          psum_d[0]  = '0;
        end
      end
      sops_pkg::SEnter: begin
        fresh_d = 1'b1;
      end
      sops_pkg::SFetch: begin
        fresh_d = 1'b0;
      end
      sops_pkg::SStep: begin
        if (leaf) begin
          if (add_sum < best_len_q) begin
            best_len_d = add_sum;
            best_ord_d = path_q;
          end
        end else begin
          if (fresh_q) begin
            cnt_d[lvl_q] = sops_pkg::LvlW'(size - 1'b1);
          end
          psum_d[lvl_nxt] = add_sum;
          lvl_d           = lvl_nxt;
        end
      end
      sops_pkg::SReturn: begin
        if (lvl_q != '0) begin
          // Rotate the tail that starts at the returning level left by one.
          for (int k = 0; k < sops_pkg::MaxPath; k++) begin
            if (sops_pkg::CntW'(k) + 1'b1 < n_q && k >= int'(lvl_q)) begin
              path_d[k] = path_q[(k + 1) % sops_pkg::MaxPath];
            end else if (sops_pkg::CntW'(k) + 1'b1 == n_q) begin
              path_d[k] = head;
            end
          end
          cnt_d[parent] = cnt_q[parent] - 1'b1;
          lvl_d         = parent;
        end
      end
      sops_pkg::SOut: begin
        if (out_fire) begin
          k_d = k_q + 1'b1;
        end
      end
      default: begin
        k_d = k_q;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sops_pkg::SIdle;
      count_q    <= '0;
      n_q        <= '0;
      lvl_q      <= '0;
      k_q        <= '0;
      fresh_q    <= 1'b0;
      best_len_q <= sops_pkg::LenInf;
      for (int i = 0; i < sops_pkg::MaxPath; i++) begin
        cnt_q[i]  <= '0;
        psum_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      n_q        <= n_d;
      lvl_q      <= lvl_d;
      k_q        <= k_d;
      fresh_q    <= fresh_d;
      best_len_q <= best_len_d;
      cnt_q      <= cnt_d;
      psum_q     <= psum_d;
    end
  end

  // Path list and best order carry no reset.
  always_ff @(posedge clk_i) begin
    path_q     <= path_d;
    best_ord_q <= best_ord_d;
  end

endmodule

>>> sv/sops_ram.sv
`timescale 1ns / 1ps

module sops_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> bench/shortest_open_path_search_top_test.sv
`timescale 1ns / 1ps

module shortest_open_path_search_top_test;

  // Command 3 has no meaning in the block and must be dropped without effect.
  localparam logic [sops_pkg::CmdW-1:0] CmdIgnored = 2'd3;
  localparam int TotalBeats = 100;
  localparam int CalmBeats  = 25;

  typedef struct packed {
    logic [sops_pkg::CmdW-1:0]  cmd;
    logic [sops_pkg::NodeW-1:0] src;
    logic [sops_pkg::NodeW-1:0] dst;
    logic [sops_pkg::DistW-1:0] leg;
    logic [sops_pkg::NodeW-1:0] node;
  } sops_beat_t;

  typedef struct packed {
    logic [sops_pkg::NodeW-1:0] node;
    logic [sops_pkg::PosW-1:0]  pos;
    logic [sops_pkg::TotW-1:0]  total;
    logic                       no_path;
    logic                       last;
  } route_beat_t;

  typedef struct packed {
    sops_beat_t  beat;
    logic        typed;
    logic        all_max;
    route_beat_t want;
  } plan_row_t;

  localparam route_beat_t NoRoute =
    '{node: '0, pos: '0, total: '0, no_path: 1'b1, last: 1'b1};

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [sops_pkg::CmdW-1:0]  command_i = CmdIgnored;
  logic [sops_pkg::NodeW-1:0] from_node_i = '0;
  logic [sops_pkg::NodeW-1:0] to_node_i = '0;
  logic [sops_pkg::DistW-1:0] distance_i = '0;
  logic [sops_pkg::NodeW-1:0] node_id_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [sops_pkg::NodeW-1:0] order_node_o;
  logic [sops_pkg::PosW-1:0]  position_o;
  logic [sops_pkg::TotW-1:0]  total_length_o;
  logic                       no_path_o;
  logic                       last_o;

  // Shadow copy of the block state, updated on every accepted input beat.
  logic [sops_pkg::DistW-1:0] dist_mem [sops_pkg::DistDepth];
  bit                         dist_known [sops_pkg::DistDepth];
  logic [sops_pkg::NodeW-1:0] node_list [sops_pkg::MaxPath];
  int unsigned                node_cnt;
  logic [sops_pkg::NodeW-1:0] best_route [sops_pkg::MaxPath];
  logic [31:0]                best_len;
  route_beat_t                expected_route [$];

  int          errors;
  int          beats_sent;
  int          searches;
  int          route_beats_seen;
  int          gap_pct = 20;
  int          stall_pct = 20;
  bit          calm;
  int          stall_left;
  route_beat_t got_route;
  route_beat_t want_route;
  plan_row_t   plan [$];

  shortest_open_path_search_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .from_node_i    (from_node_i),
    .to_node_i      (to_node_i),
    .distance_i     (distance_i),
    .node_id_i      (node_id_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .order_node_o   (order_node_o),
    .position_o     (position_o),
    .total_length_o (total_length_o),
    .no_path_o      (no_path_o),
    .last_o         (last_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [31:0] hop(logic [sops_pkg::NodeW-1:0] a,
                                      logic [sops_pkg::NodeW-1:0] b);
    return {12'h0, dist_mem[{a, b}]};
  endfunction

  function automatic void queue_route(route_beat_t r);
    expected_route = {expected_route, r};
  endfunction

  // Depth-first search over the orderings that keep the first node fixed. The
  // tail below each level is rotated left by one after every branch, so the
  // orderings come in the same sequence as in the block and ties resolve alike.
  function automatic void find_best_route(int unsigned n);
    logic [sops_pkg::NodeW-1:0] lst [sops_pkg::MaxPath];
    int unsigned                left [sops_pkg::MaxPath];
    logic [31:0]                acc [sops_pkg::MaxPath];
    logic [31:0]                t;
    logic [sops_pkg::NodeW-1:0] head;
    int unsigned                lvl;
    bit                         down;
    bit                         leave;
    bit                         busy;
    lst = node_list;
    best_len = {8'h0, sops_pkg::LenInf};
    acc[0] = '0;
    lvl = 0;
    down = 1'b1;
    busy = 1'b1;
    while (busy) begin
      leave = 1'b1;
      if (down) begin
        // A partial length strictly above the best one is not extended.
        if (acc[lvl] <= best_len) begin
          if (n - lvl == 2) begin
            t = acc[lvl] + hop(lst[lvl], lst[lvl + 1]);
            if (t < best_len) begin
              best_len = t;
              best_route = lst;
            end
          end else begin
            left[lvl] = n - lvl - 1;
            acc[lvl + 1] = acc[lvl] + hop(lst[lvl], lst[lvl + 1]);
            lvl++;
            leave = 1'b0;
          end
        end
      end else begin
        // Back from a branch: rotate the tail and try the next one, if any.
        head = lst[lvl + 1];
        for (int k = lvl + 1; k < n - 1; k++) lst[k] = lst[k + 1];
        lst[n - 1] = head;
        left[lvl]--;
        if (left[lvl] != 0) begin
          acc[lvl + 1] = acc[lvl] + hop(lst[lvl], lst[lvl + 1]);
          lvl++;
          down = 1'b1;
          leave = 1'b0;
        end
      end
      if (leave) begin
        if (lvl == 0) begin
          busy = 1'b0;
        end else begin
          lvl--;
          down = 1'b0;
        end
      end
    end
  endfunction

  // Apply one accepted input beat and queue the path beats it should cause.
  function automatic void predict_route(sops_beat_t b, logic typed, route_beat_t want);
    int unsigned n;
    route_beat_t r;
    case (b.cmd)
      sops_pkg::CmdWrite: begin
        dist_mem[{b.src, b.dst}] = b.leg;
        dist_known[{b.src, b.dst}] = 1'b1;
      end
      sops_pkg::CmdAppend: begin
        if (node_cnt < sops_pkg::MaxPath) begin
          node_list[node_cnt] = b.node;
          node_cnt++;
        end
      end
      sops_pkg::CmdStart: begin
        n = node_cnt;
        node_cnt = 0;
        searches++;
        if (typed) begin
          queue_route(want);
        end else if (n < 2) begin
          queue_route(NoRoute);
        end else begin
          find_best_route(n);
          for (int k = 0; k < n; k++) begin
            r.node = best_route[k];
            r.pos = sops_pkg::PosW'(k);
            r.total = best_len[sops_pkg::TotW-1:0];
            r.no_path = 1'b0;
            r.last = (k + 1 == n);
            queue_route(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic sops_beat_t mk_beat(logic [sops_pkg::CmdW-1:0] cmd, int src, int dst,
                                         logic [sops_pkg::DistW-1:0] leg, int node);
    sops_beat_t b;
    b.cmd = cmd;
    b.src = sops_pkg::NodeW'(src);
    b.dst = sops_pkg::NodeW'(dst);
    b.leg = leg;
    b.node = sops_pkg::NodeW'(node);
    return b;
  endfunction

  function automatic void add_row(logic [sops_pkg::CmdW-1:0] cmd, int src, int dst,
                                  logic [sops_pkg::DistW-1:0] leg, int node,
                                  logic typed, logic all_max);
    plan_row_t r;
    r.beat = mk_beat(cmd, src, dst, leg, node);
    r.typed = typed;
    r.all_max = all_max;
    r.want = typed ? NoRoute : '0;
    plan = {plan, r};
  endfunction

  // Distances lean toward zero, the maximum and a few shared values for ties.
  function automatic logic [sops_pkg::DistW-1:0] pick_dist();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3: return sops_pkg::DistW'($urandom_range(1, 3)) << 8;
      default: return sops_pkg::DistW'($urandom);
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  // Drive one input beat at the falling edge, hold it until it is taken, then predict.
  task automatic send_beat(sops_beat_t b, logic typed = 1'b0, route_beat_t want = '0);
    int gap;
    gap = (!calm && $urandom_range(99) < gap_pct) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    command_i <= b.cmd;
    from_node_i <= b.src;
    to_node_i <= b.dst;
    distance_i <= b.leg;
    node_id_i <= b.node;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    predict_route(b, typed, want);
  endtask

  // A search must never read a distance that was never written, so every leg the
  // pending list can use gets a value before the start beat.
  task automatic fill_gaps(logic all_max);
    int unsigned n;
    logic [sops_pkg::DistAw-1:0] idx;
    n = node_cnt;
    for (int i = 0; i < n; i++) begin
      for (int j = 1; j < n; j++) begin
        idx = {node_list[i], node_list[j]};
        if (i != j && !dist_known[idx])
          send_beat(mk_beat(sops_pkg::CmdWrite, int'(node_list[i]), int'(node_list[j]),
                            all_max ? '1 : pick_dist(), 0));
      end
    end
  endtask

  task automatic drain_routes();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_route.size() != 0) @(posedge clk_i);
  endtask

  // Output side: ready drops in random bursts, none once the run turns calm.
  always @(negedge clk_i) begin
    if (calm) begin
      stall_left = 0;
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(17);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each accepted path beat with the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_route = {order_node_o, position_o, total_length_o, no_path_o, last_o};
      route_beats_seen++;
      if (expected_route.size() == 0) begin
        errors++;
        $display("%0t: unexpected path beat node %0d pos %0d total 0x%0h no_path %b last %b",
                 $time, got_route.node, got_route.pos, got_route.total,
                 got_route.no_path, got_route.last);
      end else begin
        want_route = expected_route.pop_front();
        check_field("order_node", 32'(want_route.node), 32'(got_route.node));
        check_field("position", 32'(want_route.pos), 32'(got_route.pos));
        check_field("total_length", 32'(want_route.total), 32'(got_route.total));
        check_field("no_path", 32'(want_route.no_path), 32'(got_route.no_path));
        check_field("last", 32'(want_route.last), 32'(got_route.last));
      end
    end
  end

  initial begin : stimulus
    int n;
    logic [sops_pkg::CmdW-1:0] cmd;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: empty and single-node lists, the longest single leg, an
    // ignored command inside a list, a tie, and a full list of longest legs
    // that overflows.
    add_row(sops_pkg::CmdStart,   0,  0, '0,      0, 1'b1, 1'b0);
    add_row(sops_pkg::CmdAppend,  0,  0, '0,      5, 1'b0, 1'b0);
    add_row(sops_pkg::CmdStart,   0,  0, '0,      0, 1'b1, 1'b0);
    add_row(sops_pkg::CmdWrite,   0, 15, '1,      0, 1'b0, 1'b0);
    add_row(sops_pkg::CmdWrite,  15,  0, '0,      0, 1'b0, 1'b0);
    add_row(sops_pkg::CmdAppend,  0,  0, '0,      0, 1'b0, 1'b0);
    add_row(sops_pkg::CmdAppend,  0,  0, '0,     15, 1'b0, 1'b0);
    add_row(sops_pkg::CmdStart,   0,  0, '0,      0, 1'b0, 1'b0);
    add_row(sops_pkg::CmdWrite,   1,  2, 'h100,   0, 1'b0, 1'b0);
    add_row(sops_pkg::CmdWrite,   1,  3, 'h100,   0, 1'b0, 1'b0);
    add_row(sops_pkg::CmdWrite,   2,  3, 'h100,   0, 1'b0, 1'b0);
    add_row(sops_pkg::CmdWrite,   3,  2, 'h100,   0, 1'b0, 1'b0);
    add_row(sops_pkg::CmdAppend,  0,  0, '0,      1, 1'b0, 1'b0);
    add_row(sops_pkg::CmdAppend,  0,  0, '0,      2, 1'b0, 1'b0);
    add_row(CmdIgnored,          15, 15, '1,     15, 1'b0, 1'b0);
    add_row(sops_pkg::CmdAppend,  0,  0, '0,      3, 1'b0, 1'b0);
    add_row(sops_pkg::CmdStart,   0,  0, '0,      0, 1'b0, 1'b0);
    for (int k = 0; k < sops_pkg::MaxPath; k++)
      add_row(sops_pkg::CmdAppend, 0, 0, '0, 8 + k % 2, 1'b0, 1'b0);
    add_row(sops_pkg::CmdAppend,  0,  0, '0,      7, 1'b0, 1'b0);
    add_row(sops_pkg::CmdStart,   0,  0, '0,      0, 1'b0, 1'b1);

    foreach (plan[i]) begin
      if (plan[i].beat.cmd == sops_pkg::CmdStart) fill_gaps(plan[i].all_max);
      send_beat(plan[i].beat, plan[i].typed, plan[i].want);
    end
    // Hold the input side until every path beat so far has come out.
    drain_routes();

    // Random part: mostly whole jobs (list, legs, start), some noise and short lists.
    while (beats_sent < TotalBeats) begin
      calm = beats_sent >= TotalBeats - CalmBeats;
      gap_pct = 15 * $urandom_range(3);
      stall_pct = 15 * $urandom_range(3);
      case ($urandom_range(9))
        0: begin
          repeat ($urandom_range(1, 4)) begin
            cmd = ($urandom_range(9) == 0) ? sops_pkg::CmdAppend :
                  ($urandom_range(1) ? CmdIgnored : sops_pkg::CmdWrite);
            send_beat(mk_beat(cmd, $urandom_range(15), $urandom_range(15),
                              sops_pkg::DistW'($urandom), $urandom_range(15)));
          end
        end
        1: begin
          if (node_cnt == 0 && $urandom_range(1))
            send_beat(mk_beat(sops_pkg::CmdAppend, 0, 0, '0, $urandom_range(15)));
          fill_gaps(1'b0);
          send_beat(mk_beat(sops_pkg::CmdStart, 0, 0, '0, 0));
        end
        default: begin
          n = $urandom_range(2, 5);
          repeat (n) send_beat(mk_beat(sops_pkg::CmdAppend, 0, 0, '0, $urandom_range(15)));
          repeat ($urandom_range(3))
            send_beat(mk_beat(sops_pkg::CmdWrite,
                              int'(node_list[$urandom_range(node_cnt - 1)]),
                              int'(node_list[$urandom_range(node_cnt - 1)]),
                              pick_dist(), 0));
          fill_gaps(1'b0);
          send_beat(mk_beat(sops_pkg::CmdStart, 0, 0, '0, 0));
        end
      endcase
      if ($urandom_range(7) == 0) drain_routes();
    end

    // Wait for the last path beats, then watch a little longer for strays.
    drain_routes();
    repeat (50) @(posedge clk_i);

    $display("Sent %0d write, append, start and ignored beats and ran %0d searches over",
             beats_sent, searches);
    $display("lists of zero to eight nodes; %0d path beats were checked.", route_beats_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #36_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
